FILE: src/cp0_pkg.sv
// shared types, register numbers and constants for the cp0 tlb register unit
package cp0_pkg;

   localparam int TLB_ENTRIES = 32;
   localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   typedef enum logic [2:0] {
      OP_MFC0  = 3'd0,
      OP_MTC0  = 3'd1,
      OP_TLBR  = 3'd2,
      OP_TLBWI = 3'd3,
      OP_TLBP  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK      = 3'd0,
      ERR_RANDOM  = 3'd1,
      ERR_INDEX   = 3'd2,
      ERR_CAUSE   = 3'd3,
      ERR_UNKNOWN = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   localparam logic [4:0] R_INDEX    = 5'd0;
   localparam logic [4:0] R_RANDOM   = 5'd1;
   localparam logic [4:0] R_ENTRYLO0 = 5'd2;
   localparam logic [4:0] R_ENTRYLO1 = 5'd3;
   localparam logic [4:0] R_CONTEXT  = 5'd4;
   localparam logic [4:0] R_PAGEMASK = 5'd5;
   localparam logic [4:0] R_WIRED    = 5'd6;
   localparam logic [4:0] R_BADVADDR = 5'd8;
   localparam logic [4:0] R_COUNT    = 5'd9;
   localparam logic [4:0] R_ENTRYHI  = 5'd10;
   localparam logic [4:0] R_COMPARE  = 5'd11;
   localparam logic [4:0] R_STATUS   = 5'd12;
   localparam logic [4:0] R_CAUSE    = 5'd13;
   localparam logic [4:0] R_EPC      = 5'd14;
   localparam logic [4:0] R_PRID     = 5'd15;
   localparam logic [4:0] R_CONFIG   = 5'd16;
   localparam logic [4:0] R_WATCHLO  = 5'd18;
   localparam logic [4:0] R_WATCHHI  = 5'd19;
   localparam logic [4:0] R_TAGLO    = 5'd28;
   localparam logic [4:0] R_TAGHI    = 5'd29;

   localparam logic [31:0] MASK_INDEX    = 32'h8000003F;
   localparam logic [31:0] MASK_ENTRYLO  = 32'h3FFFFFFF;
   localparam logic [31:0] MASK_CTX_NEW  = 32'hFF800000;
   localparam logic [31:0] MASK_CTX_OLD  = 32'h007FFFF0;
   localparam logic [31:0] MASK_PAGEMASK = 32'h01FFE000;
   localparam logic [31:0] MASK_ENTRYHI  = 32'hFFFFE0FF;
   localparam logic [31:0] MASK_CAUSE_CL = 32'hFFFF7FFF;
   localparam logic [31:0] MASK_TAGLO    = 32'h0FFFFFC0;

   typedef struct packed {
      logic   load;
      logic   exec;
      logic   done;
   } cmd_type;

endpackage

FILE: src/cp0_tlb_register_unit.sv
// top level of the cp0 register unit with joint tlb
//  channel   | ports                                         | handshake
//  request   | req_operation, req_reg_number, req_write_value | start && !busy
//  response  | rsp_read_data, rsp_error_code                  | rsp_valid, one cycle
// a request's result is registered in exec and its response strobe shows in the done state,
// taken at the edge ending it; no new request is accepted until the fsm is back in idle.
// the probe compares all entries in parallel and the hit is registered first.
// reset is synchronous and clears the register file, the tlb and rsp_valid at once.
// the response cannot be stalled.
module cp0_tlb_register_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [4:0]         req_reg_number,
   input  logic signed [63:0] req_write_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_data,
   output logic [2:0]         rsp_error_code
);

   cp0_pkg::cmd_type cmd;

   cp0_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   cp0_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_reg_number  (req_reg_number),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

FILE: src/cp0_ctrl.sv
// controller state machine sequencing one request through the datapath
module cp0_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output cp0_pkg::cmd_type cmd
);

   cp0_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cp0_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         cp0_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = cp0_pkg::ST_EXEC;
            end
         end
         cp0_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = cp0_pkg::ST_DONE;
         end
         cp0_pkg::ST_DONE: begin
            cmd.done = 1'b1;
            state_in = cp0_pkg::ST_IDLE;
         end
         default: begin
            state_in = cp0_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/cp0_datapath.sv
// register file, tlb storage, probe compare and result register
module cp0_datapath (
   input  logic               clock,
   input  logic               reset,
   input  cp0_pkg::cmd_type   cmd,
   input  logic [2:0]         req_operation,
   input  logic [4:0]         req_reg_number,
   input  logic signed [63:0] req_write_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_data,
   output logic [2:0]         rsp_error_code
);

   localparam int IW = cp0_pkg::TLB_IDX_W;

   logic [31:0] regs_ff [32];
   logic [39:0] tags_ff [cp0_pkg::TLB_ENTRIES];
   logic [57:0] pages_ff [cp0_pkg::TLB_ENTRIES];

   logic [2:0]  op_ff;
   logic [4:0]  rn_ff;
   logic [63:0] val_ff;
   logic        hit_ff;
   logic [4:0]  hit_idx_ff;
   logic        valid_ff;
   logic [31:0] data_ff;
   logic [2:0]  err_ff;

   logic [31:0] hi, idx_reg;
   logic [18:0] want;
   logic        hit_in;
   logic [4:0]  hit_idx_in;
   logic [4:0]  tidx;
   logic        tidx_ok;
   logic [IW-1:0] tsel;
   logic [39:0] rtag;
   logic [57:0] rpage;
   logic [31:0] v;
   logic [31:0] lo0, lo1, pmask;
   logic [31:0] data_in;
   logic [2:0]  err_in;

   assign hi      = regs_ff[cp0_pkg::R_ENTRYHI];
   assign idx_reg = regs_ff[cp0_pkg::R_INDEX];
   assign want    = hi[31:13];
   assign tidx    = idx_reg[4:0];
   assign tidx_ok = {27'd0, tidx} < cp0_pkg::TLB_ENTRIES;
   assign tsel    = tidx[IW-1:0];
   assign rtag    = tags_ff[tsel];
   assign rpage   = pages_ff[tsel];
   assign v       = val_ff[31:0];
   assign lo0     = regs_ff[cp0_pkg::R_ENTRYLO0];
   assign lo1     = regs_ff[cp0_pkg::R_ENTRYLO1];
   assign pmask   = regs_ff[cp0_pkg::R_PAGEMASK];

   // parallel probe compare, lowest-numbered hit wins
   always_comb begin
      logic [18:0] keep;
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int i = cp0_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
         keep = ~{7'd0, tags_ff[i][39:28]};
         if (((tags_ff[i][27:9] & keep) == (want & keep)) &&
             (tags_ff[i][8] || (tags_ff[i][7:0] == hi[7:0]))) begin
            hit_in     = 1'b1;
            hit_idx_in = 5'(i);
         end
      end
   end

   always_comb begin
      data_in = '0;
      err_in  = cp0_pkg::ERR_OK;
      if (op_ff == cp0_pkg::OP_MFC0) begin
         if (rn_ff == cp0_pkg::R_RANDOM) err_in = cp0_pkg::ERR_RANDOM;
         else data_in = regs_ff[rn_ff];
      end else if (op_ff == cp0_pkg::OP_MTC0) begin
         case (rn_ff)
            cp0_pkg::R_INDEX:
               if (v[5]) err_in = cp0_pkg::ERR_INDEX;
            cp0_pkg::R_RANDOM, cp0_pkg::R_BADVADDR, cp0_pkg::R_PRID,
            cp0_pkg::R_ENTRYLO0, cp0_pkg::R_ENTRYLO1, cp0_pkg::R_CONTEXT,
            cp0_pkg::R_PAGEMASK, cp0_pkg::R_WIRED, cp0_pkg::R_ENTRYHI,
            cp0_pkg::R_COMPARE, cp0_pkg::R_COUNT, cp0_pkg::R_STATUS,
            cp0_pkg::R_EPC, cp0_pkg::R_CONFIG, cp0_pkg::R_WATCHLO,
            cp0_pkg::R_WATCHHI, cp0_pkg::R_TAGLO, cp0_pkg::R_TAGHI: ;
            cp0_pkg::R_CAUSE:
               if (val_ff != 64'd0) err_in = cp0_pkg::ERR_CAUSE;
            default: err_in = cp0_pkg::ERR_UNKNOWN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         rn_ff  <= req_reg_number;
         val_ff <= req_write_value;
      end
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      if (cmd.exec) begin
         data_ff <= data_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.exec;
      end
   end

   // register and tlb updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
         for (int i = 0; i < cp0_pkg::TLB_ENTRIES; i++) begin
            tags_ff[i]  <= '0;
            pages_ff[i] <= '0;
         end
      end else if (cmd.exec) begin
         case (op_ff)
            cp0_pkg::OP_MTC0: begin
               case (rn_ff)
                  cp0_pkg::R_INDEX: regs_ff[rn_ff] <= v & cp0_pkg::MASK_INDEX;
                  cp0_pkg::R_ENTRYLO0, cp0_pkg::R_ENTRYLO1:
                     regs_ff[rn_ff] <= v & cp0_pkg::MASK_ENTRYLO;
                  cp0_pkg::R_CONTEXT:
                     regs_ff[rn_ff] <= (v & cp0_pkg::MASK_CTX_NEW) |
                        (regs_ff[cp0_pkg::R_CONTEXT] & cp0_pkg::MASK_CTX_OLD);
                  cp0_pkg::R_PAGEMASK: regs_ff[rn_ff] <= v & cp0_pkg::MASK_PAGEMASK;
                  cp0_pkg::R_WIRED: begin
                     regs_ff[rn_ff] <= v;
                     regs_ff[cp0_pkg::R_RANDOM] <= 32'd31;
                  end
                  cp0_pkg::R_ENTRYHI: regs_ff[rn_ff] <= v & cp0_pkg::MASK_ENTRYHI;
                  cp0_pkg::R_COMPARE: begin
                     regs_ff[rn_ff] <= v;
                     regs_ff[cp0_pkg::R_CAUSE] <=
                        regs_ff[cp0_pkg::R_CAUSE] & cp0_pkg::MASK_CAUSE_CL;
                  end
                  cp0_pkg::R_CAUSE:
                     if (val_ff == 64'd0) regs_ff[rn_ff] <= '0;
                  cp0_pkg::R_COUNT, cp0_pkg::R_STATUS, cp0_pkg::R_EPC,
                  cp0_pkg::R_CONFIG, cp0_pkg::R_WATCHLO, cp0_pkg::R_WATCHHI:
                     regs_ff[rn_ff] <= v;
                  cp0_pkg::R_TAGLO: regs_ff[rn_ff] <= v & cp0_pkg::MASK_TAGLO;
                  cp0_pkg::R_TAGHI: regs_ff[rn_ff] <= '0;
                  default: ;
               endcase
            end
            cp0_pkg::OP_TLBR: begin
               if (tidx_ok) begin
                  regs_ff[cp0_pkg::R_PAGEMASK] <= {7'd0, rtag[39:28], 13'd0};
                  regs_ff[cp0_pkg::R_ENTRYHI]  <= {rtag[27:9], 5'd0, rtag[7:0]};
                  regs_ff[cp0_pkg::R_ENTRYLO0] <= {2'd0, rpage[28:0], rtag[8]};
                  regs_ff[cp0_pkg::R_ENTRYLO1] <= {2'd0, rpage[57:29], rtag[8]};
               end
            end
            cp0_pkg::OP_TLBWI: begin
               if (tidx_ok) begin
                  tags_ff[tsel]  <= {pmask[24:13], hi[31:13], lo0[0] & lo1[0], hi[7:0]};
                  pages_ff[tsel] <= {lo1[29:1], lo0[29:1]};
               end
            end
            cp0_pkg::OP_TLBP: begin
               if (hit_ff) regs_ff[cp0_pkg::R_INDEX] <= {27'd0, hit_idx_ff};
               else regs_ff[cp0_pkg::R_INDEX] <= idx_reg | 32'h80000000;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_read_data  = data_ff;
   assign rsp_error_code = err_ff;

endmodule

FILE: test/cp0_tlb_register_unit_tb.sv
// testbench for the cp0 register unit: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module cp0_tlb_register_unit_tb;

   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] OP_UNDEFINED = 3'd7;
   localparam logic [4:0] R_RESERVED   = 5'd7;
   localparam logic [4:0] R_LAST       = 5'd31;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_operation = '0;
   logic [4:0]         req_reg_number = '0;
   logic signed [63:0] req_write_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_data;
   logic [2:0]         rsp_error_code;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  err;
   } cp0_result_type;

   logic [31:0]    cop_regs [32];
   logic [39:0]    tag_mem [cp0_pkg::TLB_ENTRIES];
   logic [57:0]    page_mem [cp0_pkg::TLB_ENTRIES];
   cp0_result_type pending_results [$];
   int             error_count = 0;
   int             response_count = 0;
   int             request_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;

   cp0_tlb_register_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_reg_number(req_reg_number),
      .req_write_value(req_write_value), .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data), .rsp_error_code(rsp_error_code)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h (response %0d)", what, got, want,
               response_count);
   endtask

   // predictor
   function automatic logic [2:0] predict_move_to(input logic [4:0] rn,
                                                  input logic [63:0] full);
      logic [31:0] v;
      v = full[31:0];
      case (rn)
         cp0_pkg::R_INDEX: begin
            cop_regs[cp0_pkg::R_INDEX] = v & cp0_pkg::MASK_INDEX;
            return (cop_regs[cp0_pkg::R_INDEX][5:0] > 31) ? cp0_pkg::ERR_INDEX
                                                          : cp0_pkg::ERR_OK;
         end
         cp0_pkg::R_RANDOM, cp0_pkg::R_BADVADDR, cp0_pkg::R_PRID: return cp0_pkg::ERR_OK;
         cp0_pkg::R_ENTRYLO0, cp0_pkg::R_ENTRYLO1: cop_regs[rn] = v & cp0_pkg::MASK_ENTRYLO;
         cp0_pkg::R_CONTEXT: cop_regs[cp0_pkg::R_CONTEXT] = (v & cp0_pkg::MASK_CTX_NEW) |
               (cop_regs[cp0_pkg::R_CONTEXT] & cp0_pkg::MASK_CTX_OLD);
         cp0_pkg::R_PAGEMASK: cop_regs[cp0_pkg::R_PAGEMASK] = v & cp0_pkg::MASK_PAGEMASK;
         cp0_pkg::R_WIRED: begin
            cop_regs[cp0_pkg::R_WIRED] = v;
            cop_regs[cp0_pkg::R_RANDOM] = 32'd31;
         end
         cp0_pkg::R_ENTRYHI: cop_regs[cp0_pkg::R_ENTRYHI] = v & cp0_pkg::MASK_ENTRYHI;
         cp0_pkg::R_COMPARE: begin
            cop_regs[cp0_pkg::R_COMPARE] = v;
            cop_regs[cp0_pkg::R_CAUSE] = cop_regs[cp0_pkg::R_CAUSE] & cp0_pkg::MASK_CAUSE_CL;
         end
         cp0_pkg::R_CAUSE: begin
            if (full != 64'd0) return cp0_pkg::ERR_CAUSE;
            cop_regs[cp0_pkg::R_CAUSE] = 32'd0;
         end
         cp0_pkg::R_COUNT, cp0_pkg::R_STATUS, cp0_pkg::R_EPC, cp0_pkg::R_CONFIG,
         cp0_pkg::R_WATCHLO, cp0_pkg::R_WATCHHI: cop_regs[rn] = v;
         cp0_pkg::R_TAGLO: cop_regs[cp0_pkg::R_TAGLO] = v & cp0_pkg::MASK_TAGLO;
         cp0_pkg::R_TAGHI: cop_regs[cp0_pkg::R_TAGHI] = 32'd0;
         default: return cp0_pkg::ERR_UNKNOWN;
      endcase
      return cp0_pkg::ERR_OK;
   endfunction

   function automatic cp0_result_type predict_cp0(input logic [2:0] op,
                                                  input logic [4:0] rn,
                                                  input logic [63:0] full);
      cp0_result_type r;
      int             idx;
      logic [39:0]    tag;
      logic [57:0]    pg;
      logic [18:0]    keep;
      logic [31:0]    hi;
      logic [31:0]    lo0;
      logic [31:0]    lo1;
      r.data = '0;
      r.err = cp0_pkg::ERR_OK;
      idx = cop_regs[cp0_pkg::R_INDEX][4:0];
      hi = cop_regs[cp0_pkg::R_ENTRYHI];
      case (op)
         cp0_pkg::OP_MFC0: begin
            if (rn == cp0_pkg::R_RANDOM) r.err = cp0_pkg::ERR_RANDOM;
            else r.data = cop_regs[rn];
         end
         cp0_pkg::OP_MTC0: r.err = predict_move_to(rn, full);
         cp0_pkg::OP_TLBR: if (idx < cp0_pkg::TLB_ENTRIES) begin
            tag = tag_mem[idx];
            pg = page_mem[idx];
            cop_regs[cp0_pkg::R_PAGEMASK] = {7'd0, tag[39:28], 13'd0};
            cop_regs[cp0_pkg::R_ENTRYHI] = {tag[27:9], 5'd0, tag[7:0]};
            cop_regs[cp0_pkg::R_ENTRYLO0] = {2'b00, pg[28:0], tag[8]};
            cop_regs[cp0_pkg::R_ENTRYLO1] = {2'b00, pg[57:29], tag[8]};
         end
         cp0_pkg::OP_TLBWI: if (idx < cp0_pkg::TLB_ENTRIES) begin
            lo0 = cop_regs[cp0_pkg::R_ENTRYLO0];
            lo1 = cop_regs[cp0_pkg::R_ENTRYLO1];
            tag_mem[idx] = {cop_regs[cp0_pkg::R_PAGEMASK][24:13], hi[31:13],
                            lo0[0] & lo1[0], hi[7:0]};
            page_mem[idx] = {lo1[29:1], lo0[29:1]};
         end
         cp0_pkg::OP_TLBP: begin
            cop_regs[cp0_pkg::R_INDEX][31] = 1'b1;
            for (int i = 0; i < cp0_pkg::TLB_ENTRIES; i++) begin
               tag = tag_mem[i];
               keep = ~{7'd0, tag[39:28]};
               if (((tag[27:9] & keep) == (hi[31:13] & keep)) &&
                   (tag[8] || tag[7:0] == hi[7:0])) begin
                  cop_regs[cp0_pkg::R_INDEX] = 32'(i);
                  break;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      cp0_result_type want;
      if (!reset && rsp_valid) begin
         response_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_read_data, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.data)
               report_mismatch("read_data", rsp_read_data, want.data);
            if (rsp_error_code !== want.err)
               report_mismatch("error_code", {29'd0, rsp_error_code}, {29'd0, want.err});
         end
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [4:0] rn,
                               input logic [63:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_reg_number <= rn;
      req_write_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_cp0(op, rn, val));
      request_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = 64'd0;
         1: v = '1;
         2: v = {32'd0, v[31:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_request(cp0_pkg::OP_MFC0, cp0_pkg::R_RANDOM, 64'd0);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_WIRED, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(cp0_pkg::OP_MFC0, cp0_pkg::R_WIRED, 64'd0);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_INDEX, 64'h8000_0000_FFFF_FFFF);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_INDEX, 64'h0000_0000_0000_0005);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_CAUSE, 64'h8000_0000_0000_0000);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_CAUSE, 64'd0);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_COMPARE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(cp0_pkg::OP_MTC0, R_RESERVED, 64'd1);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_CONTEXT, '1);
      send_request(cp0_pkg::OP_MFC0, cp0_pkg::R_CONTEXT, 64'd0);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_ENTRYHI, 64'hFFFF_FFFF);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_ENTRYLO0, 64'hFFFF_FFFF);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_ENTRYLO1, 64'h1);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_PAGEMASK, 64'hFFFF_FFFF);
      send_request(cp0_pkg::OP_TLBWI, cp0_pkg::R_INDEX, 64'd0);
      send_request(cp0_pkg::OP_TLBR, cp0_pkg::R_INDEX, 64'd0);
      send_request(cp0_pkg::OP_TLBP, cp0_pkg::R_INDEX, 64'd0);
      send_request(cp0_pkg::OP_MFC0, cp0_pkg::R_INDEX, 64'd0);
      send_request(cp0_pkg::OP_MTC0, cp0_pkg::R_TAGHI, '1);
      send_request(cp0_pkg::OP_MFC0, R_LAST, 64'd0);
      send_request(OP_UNDEFINED, cp0_pkg::R_ENTRYLO1, '1);
      wait_drained();
   endtask

   task automatic test_random(input int count);
      logic [2:0]  op;
      logic [4:0]  rn;
      logic [63:0] val;
      for (int n = 0; n < count; n++) begin
         op = 3'($urandom_range(4));
         if ($urandom_range(19) == 0) op = 3'($urandom_range(7, 5));
         rn = 5'($urandom);
         val = random_value();
         // steer entryhi and index towards the few live tlb entries to get probe hits
         if (op == cp0_pkg::OP_MTC0 && $urandom_range(2) == 0) begin
            rn = $urandom_range(1) ? cp0_pkg::R_INDEX : cp0_pkg::R_ENTRYHI;
            if (rn == cp0_pkg::R_INDEX) val[5:0] = 6'($urandom_range(3));
            else val[31:13] = 19'($urandom_range(3));
         end
         send_request(op, rn, val);
      end
   endtask

   task automatic test_idle_phases();
      send_idle_pct = 0;
      test_random(400);
      send_idle_pct = 86;
      test_random(350);
      wait_drained();
      send_idle_pct = 19;
      test_random(350);
      send_idle_pct = 0;
      test_random(400);
   endtask

   initial begin
      for (int i = 0; i < 32; i++) cop_regs[i] = '0;
      for (int i = 0; i < cp0_pkg::TLB_ENTRIES; i++) begin
         tag_mem[i] = '0;
         page_mem[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_idle_phases();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d responses: all operations, masks, tlb and probe",
               request_count, response_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/cp0_pkg.sv
src/cp0_ctrl.sv
src/cp0_datapath.sv
src/cp0_tlb_register_unit.sv
test/cp0_tlb_register_unit_tb.sv
